// ===== hw/rtl/tkv_pkg.sv =====
`default_nettype none

package tkv_pkg;

	localparam int VAL_W     = 32;
	localparam int POS_W     = 16;
	localparam int CNT_OUT_W = 3;
	localparam int OUT_POS_N = 4;
	localparam int CAP_W     = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	// byte address of the capacity register
	localparam logic [1:0] ADDR_CAPACITY = 2'd0;

	typedef enum logic [1:0] {
		CMD_OFFER = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		logic match;  // probe equals key
		logic below;  // probe signed-less-than floor
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tkv_cmp.sv =====
`default_nettype none

module tkv_cmp (
	input  logic signed [tkv_pkg::VAL_W-1:0] x,
	input  logic signed [tkv_pkg::VAL_W-1:0] key,
	input  logic signed [tkv_pkg::VAL_W-1:0] floor,
	output tkv_pkg::cmp_res_t                res
);

	always_comb begin
		res.match = (x == key);
		res.below = (x < floor);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tkv_store.sv =====
`default_nettype none

module tkv_store #(
	parameter int TABLE_DEPTH    = 8,
	parameter int POSITION_DEPTH = 4,
	localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int PW = (POSITION_DEPTH > 1) ? $clog2(POSITION_DEPTH) : 1,
	localparam int CW = $clog2(POSITION_DEPTH + 1)
) (
	input  logic                                    clk,
	input  logic                                    meta_we,
	input  logic [SW-1:0]                           meta_waddr,
	input  logic [tkv_pkg::VAL_W-1:0]               meta_wval,
	input  logic [CW-1:0]                           meta_wcnt,
	input  logic                                    meta_wovf,
	input  logic [SW-1:0]                           meta_raddr,
	output logic [tkv_pkg::VAL_W-1:0]               meta_rval,
	output logic [CW-1:0]                           meta_rcnt,
	output logic                                    meta_rovf,
	input  logic                                    pos_we,
	input  logic [SW+PW-1:0]                        pos_waddr,
	input  logic [tkv_pkg::POS_W-1:0]               pos_wdata,
	input  logic [SW+PW-1:0]                        pos_raddr,
	output logic [tkv_pkg::POS_W-1:0]               pos_rdata
);

	localparam int PDEPTH = TABLE_DEPTH * (2 ** PW);

	logic [tkv_pkg::VAL_W-1:0] val_mem [TABLE_DEPTH];
	logic [CW-1:0]             cnt_mem [TABLE_DEPTH];
	logic                      ovf_mem [TABLE_DEPTH];
	logic [tkv_pkg::POS_W-1:0] pos_mem [PDEPTH];

	always_ff @(posedge clk) begin
		if (meta_we) begin
			val_mem[meta_waddr] <= meta_wval;
			cnt_mem[meta_waddr] <= meta_wcnt;
			ovf_mem[meta_waddr] <= meta_wovf;
		end
		meta_rval <= val_mem[meta_raddr];
		meta_rcnt <= cnt_mem[meta_raddr];
		meta_rovf <= ovf_mem[meta_raddr];
	end

	// positions of slot s live at {s, k}
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
		pos_rdata <= pos_mem[pos_raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/top_k_values_with_positions_core.sv =====
`default_nettype none

// Channel   Dir  Handshake                Payload
// cfg       in   psel/penable/pready      capacity at paddr 0
// s_axis    in   s_axis_tvalid/tready     tuser = command, tdata = value, position
// m_axis    out  m_axis_tvalid/tready     tuser = entry_valid, tlast = last, tdata = entry
//
// Offer: accepted in idle, then one pass of the shared comparator over the held slots
// (skipped when the table is empty) and a decide state; a match ends the pass without decide.
// Read-out: per entry a meta read and a load, a read and a write state per recorded position, then emit.
// Clear and unknown commands finish in the idle state. Input is taken only in the idle state.
// Reset empties the table and sets capacity to 8; table memories are not cleared.
// A finished beat waits in the output register; the sequencer stalls in the emit state
// only while that register still holds a beat that has not been taken.
module top_k_values_with_positions_core #(
	parameter int TABLE_DEPTH    = 8,
	parameter int POSITION_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [47:0]   s_axis_tdata,   // value[31:0], position[47:32]
	input  logic [1:0]    s_axis_tuser,   // command[1:0]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [103:0]  m_axis_tdata,   // entry_value[31:0], position_count[34:32],
	                                      // position_a[50:35], position_b[66:51],
	                                      // position_c[82:67], position_d[98:83],
	                                      // positions_overflowed[99], zero[103:100]
	output logic          m_axis_tuser,   // entry_valid
	output logic          m_axis_tlast
);

	localparam int SW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UW   = $clog2(TABLE_DEPTH + 1);
	localparam int PW   = (POSITION_DEPTH > 1) ? $clog2(POSITION_DEPTH) : 1;
	localparam int CW   = $clog2(POSITION_DEPTH + 1);
	localparam int CAPX = (UW > tkv_pkg::CAP_W) ? UW : tkv_pkg::CAP_W;
	localparam int PMAX = (POSITION_DEPTH < tkv_pkg::OUT_POS_N) ?
		POSITION_DEPTH : tkv_pkg::OUT_POS_N;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SCAN    = 8'b0000_0010,
		ST_DECIDE  = 8'b0000_0100,
		ST_RO_META = 8'b0000_1000,
		ST_RO_LOAD = 8'b0001_0000,
		ST_RO_PRD  = 8'b0010_0000,
		ST_RO_PWR  = 8'b0100_0000,
		ST_RO_EMIT = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [tkv_pkg::CAP_W-1:0] cap_q;
	logic [UW-1:0]             used_q;
	logic [UW-1:0]             issue_q;
	logic                      dv_q;
	logic [SW-1:0]             cidx_q;
	logic [SW-1:0]             low_slot_q;
	logic signed [31:0]        low_val_q;
	logic signed [31:0]        value_q;
	logic [15:0]               posin_q;
	logic [SW-1:0]             ro_slot_q;
	logic [1:0]                k_q;
	logic [2:0]                npos_q;

	logic                      ent_vld_q;
	logic [31:0]               ent_val_q;
	logic [2:0]                ent_cnt_q;
	logic                      ent_ovf_q;
	logic [15:0]               ent_pos_q [tkv_pkg::OUT_POS_N];

	logic                      out_vld_q;
	logic                      out_entry_q;
	logic                      out_last_q;
	logic [31:0]               out_val_q;
	logic [2:0]                out_cnt_q;
	logic                      out_ovf_q;
	logic [15:0]               out_pos_q [tkv_pkg::OUT_POS_N];

	logic [CAPX-1:0]           cap_x;
	logic [CAPX-1:0]           cap_eff;
	logic                      room;
	logic                      in_acc;
	logic                      out_free;
	logic                      cfg_wr;
	logic                      last_cmp;
	logic                      ro_last;
	logic                      hit;
	logic [SW-1:0]             ins_slot;
	logic [7:0]                cnt_x;
	logic [2:0]                npos_rd;
	logic [2:0]                pc_rd;
	tkv_pkg::cmd_t             cmd;

	logic signed [31:0]        cmp_x;
	logic signed [31:0]        cmp_floor;
	tkv_pkg::cmp_res_t         cmp_res;

	logic                      meta_we;
	logic [SW-1:0]             meta_waddr;
	logic [31:0]               meta_wval;
	logic [CW-1:0]             meta_wcnt;
	logic                      meta_wovf;
	logic [SW-1:0]             meta_raddr;
	logic [31:0]               meta_rval;
	logic [CW-1:0]             meta_rcnt;
	logic                      meta_rovf;
	logic                      pos_we;
	logic [SW+PW-1:0]          pos_waddr;
	logic [SW+PW-1:0]          pos_raddr;
	logic [15:0]               pos_rdata;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == tkv_pkg::ADDR_CAPACITY) ?
		{{(32 - tkv_pkg::CAP_W){1'b0}}, cap_q} : 32'd0;

	always_comb begin
		cap_x = CAPX'(cap_q);
		if (cap_x == '0) begin
			cap_eff = CAPX'(1);
		end else if (cap_x > CAPX'(TABLE_DEPTH)) begin
			cap_eff = CAPX'(TABLE_DEPTH);
		end else begin
			cap_eff = cap_x;
		end
	end

	assign room     = CAPX'(used_q) < cap_eff;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign cmd      = tkv_pkg::cmd_t'(s_axis_tuser);
	assign out_free = !out_vld_q || m_axis_tready;
	assign last_cmp = (UW'(cidx_q) + UW'(1)) == used_q;
	assign ro_last  = (used_q == '0) || ((UW'(ro_slot_q) + UW'(1)) == used_q);
	assign hit      = (state_q == ST_SCAN) && dv_q && cmp_res.match;
	assign ins_slot = room ? used_q[SW-1:0] : low_slot_q;

	// count as shown on the port, and positions to fetch for read-out
	always_comb begin
		cnt_x   = 8'(meta_rcnt);
		pc_rd   = (cnt_x > 8'd7) ? 3'd7 : cnt_x[2:0];
		npos_rd = (cnt_x > 8'(PMAX)) ? 3'(PMAX) : cnt_x[2:0];
	end

	// shared comparator: match/min during the scan, final replace test in decide
	assign cmp_x     = (state_q == ST_DECIDE) ? low_val_q : $signed(meta_rval);
	assign cmp_floor = (state_q == ST_DECIDE) ? value_q : low_val_q;

	tkv_cmp u_cmp (
		.x     (cmp_x),
		.key   (value_q),
		.floor (cmp_floor),
		.res   (cmp_res)
	);

	assign meta_raddr = (state_q == ST_SCAN) ? issue_q[SW-1:0] : ro_slot_q;
	assign pos_raddr  = {ro_slot_q, PW'(k_q)};

	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = cidx_q;
		meta_wval  = meta_rval;
		meta_wcnt  = meta_rcnt;
		meta_wovf  = meta_rovf;
		pos_we     = 1'b0;
		pos_waddr  = {cidx_q, meta_rcnt[PW-1:0]};
		if (hit) begin
			meta_we = 1'b1;
			if (meta_rcnt < CW'(POSITION_DEPTH)) begin
				pos_we    = 1'b1;
				meta_wcnt = meta_rcnt + CW'(1);
			end else begin
				meta_wovf = 1'b1;
			end
		end else if (state_q == ST_DECIDE && (room || cmp_res.below)) begin
			meta_we    = 1'b1;
			meta_waddr = ins_slot;
			meta_wval  = value_q;
			meta_wcnt  = CW'(1);
			meta_wovf  = 1'b0;
			pos_we     = 1'b1;
			pos_waddr  = {ins_slot, PW'(0)};
		end
	end

	tkv_store #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.POSITION_DEPTH (POSITION_DEPTH)
	) u_store (
		.clk        (clk),
		.meta_we    (meta_we),
		.meta_waddr (meta_waddr),
		.meta_wval  (meta_wval),
		.meta_wcnt  (meta_wcnt),
		.meta_wovf  (meta_wovf),
		.meta_raddr (meta_raddr),
		.meta_rval  (meta_rval),
		.meta_rcnt  (meta_rcnt),
		.meta_rovf  (meta_rovf),
		.pos_we     (pos_we),
		.pos_waddr  (pos_waddr),
		.pos_wdata  (posin_q),
		.pos_raddr  (pos_raddr),
		.pos_rdata  (pos_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_q     <= tkv_pkg::CAP_RESET;
			used_q    <= '0;
			issue_q   <= '0;
			dv_q      <= 1'b0;
			ro_slot_q <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr && paddr == tkv_pkg::ADDR_CAPACITY) begin
				cap_q <= pwdata[tkv_pkg::CAP_W-1:0];
			end
			// a beat taken while the next one loads keeps the register full
			if (m_axis_tvalid && m_axis_tready && !(state_q == ST_RO_EMIT && out_free)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (cmd)
							tkv_pkg::CMD_OFFER: begin
								issue_q <= '0;
								dv_q    <= 1'b0;
								state_q <= (used_q == '0) ? ST_DECIDE : ST_SCAN;
							end
							tkv_pkg::CMD_READ: begin
								ro_slot_q <= '0;
								state_q   <= (used_q == '0) ? ST_RO_EMIT : ST_RO_META;
							end
							tkv_pkg::CMD_CLEAR: begin
								used_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					issue_q <= issue_q + UW'(1);
					dv_q    <= 1'b1;
					if (dv_q) begin
						if (cmp_res.match) begin
							state_q <= ST_IDLE;
						end else if (last_cmp) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (room) begin
						used_q <= used_q + UW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_RO_META: begin
					state_q <= ST_RO_LOAD;
				end
				ST_RO_LOAD: begin
					k_q     <= '0;
					state_q <= (npos_rd == 3'd0) ? ST_RO_EMIT : ST_RO_PRD;
				end
				ST_RO_PRD: begin
					state_q <= ST_RO_PWR;
				end
				ST_RO_PWR: begin
					if ((3'(k_q) + 3'd1) == npos_q) begin
						state_q <= ST_RO_EMIT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_RO_PRD;
					end
				end
				ST_RO_EMIT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						if (ro_last) begin
							state_q <= ST_IDLE;
						end else begin
							ro_slot_q <= ro_slot_q + SW'(1);
							state_q   <= ST_RO_META;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			value_q   <= $signed(s_axis_tdata[31:0]);
			posin_q   <= s_axis_tdata[47:32];
			ent_vld_q <= (used_q != '0);
			ent_val_q <= '0;
			ent_cnt_q <= '0;
			ent_ovf_q <= 1'b0;
			for (int i = 0; i < tkv_pkg::OUT_POS_N; i++) begin
				ent_pos_q[i] <= '0;
			end
		end
		if (state_q == ST_SCAN) begin
			cidx_q <= issue_q[SW-1:0];
			// lowest slot keeps the minimum on ties
			if (dv_q && (cidx_q == '0 || cmp_res.below)) begin
				low_slot_q <= cidx_q;
				low_val_q  <= $signed(meta_rval);
			end
		end
		if (state_q == ST_RO_LOAD) begin
			ent_val_q <= meta_rval;
			ent_cnt_q <= pc_rd;
			ent_ovf_q <= meta_rovf;
			npos_q    <= npos_rd;
			for (int i = 0; i < tkv_pkg::OUT_POS_N; i++) begin
				ent_pos_q[i] <= '0;
			end
		end
		if (state_q == ST_RO_PWR) begin
			ent_pos_q[k_q] <= pos_rdata;
		end
		if (state_q == ST_RO_EMIT && out_free) begin
			out_entry_q <= ent_vld_q;
			out_last_q  <= ro_last;
			out_val_q   <= ent_val_q;
			out_cnt_q   <= ent_cnt_q;
			out_ovf_q   <= ent_ovf_q;
			for (int i = 0; i < tkv_pkg::OUT_POS_N; i++) begin
				out_pos_q[i] <= ent_pos_q[i];
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_entry_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'd0, out_ovf_q, out_pos_q[3], out_pos_q[2], out_pos_q[1],
		out_pos_q[0], out_cnt_q, out_val_q};

`ifndef NO_ASSERTIONS
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && room) |=> (used_q == $past(used_q) + UW'(1)))
		else $error("table fill did not advance on insert");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CAPX'(used_q) <= CAPX'(TABLE_DEPTH))
		else $error("entries in use beyond table depth");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
		else $error("empty-table beat without tlast");

	a_pos_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RO_PWR) |-> (3'(k_q) < npos_q))
		else $error("position fetch beyond recorded count");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH = 8;
	localparam int SLOT_POS = 4;
	localparam int SETTLE = 20;        // longest offer pass plus margin
	localparam int LIMIT = 300000;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [31:0] value;
		logic [2:0]  count;
		logic [15:0] pos_a;
		logic [15:0] pos_b;
		logic [15:0] pos_c;
		logic [15:0] pos_d;
		logic        ovf;
		logic        last;
	} entry_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  cmd;
		logic [31:0] value;
		logic [15:0] pos;
		logic [3:0]  cap;
		bit          typed;
		entry_t      want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // value[31:0], position[47:32]
	logic [1:0] s_axis_tuser = '0;    // command[1:0]
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;       // value, count, pos a..d, overflow, zero pad
	logic m_axis_tuser;               // entry_valid
	logic m_axis_tlast;

	// table mirror
	logic [31:0] held_val [DEPTH];
	logic [2:0]  hit_count [DEPTH];
	logic [15:0] hit_pos [DEPTH][SLOT_POS];
	logic        hit_ovf [DEPTH];
	int          held_n = 0;
	logic [3:0]  capacity = tkv_pkg::CAP_RESET;

	entry_t read_out [DEPTH];
	entry_t expected_entries [$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;

	top_k_values_with_positions_core u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_position(int slot, logic [15:0] p);
		if (hit_count[slot] < SLOT_POS) begin
			hit_pos[slot][hit_count[slot]] = p;
			hit_count[slot] = hit_count[slot] + 3'd1;
		end else begin
			hit_ovf[slot] = 1'b1;
		end
	endfunction

	function automatic void open_slot(int slot, logic [31:0] v, logic [15:0] p);
		held_val[slot] = v;
		hit_count[slot] = '0;
		hit_ovf[slot] = 1'b0;
		note_position(slot, p);
	endfunction

	// updates the mirror for one beat, returns how many entries it reads out
	function automatic int track_item(logic [1:0] cmd, logic [31:0] v, logic [15:0] p);
		int eff;
		int low;
		int n;
		bit found;
		logic [15:0] shown [SLOT_POS];
		eff = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : int'(capacity));
		n = 0;
		found = 1'b0;
		case (cmd)
			tkv_pkg::CMD_OFFER: begin
				for (int i = 0; i < held_n; i++)
					if (!found && held_val[i] == v) begin
						note_position(i, p);
						found = 1'b1;
					end
				if (!found) begin
					if (held_n < eff) begin
						open_slot(held_n, v, p);
						held_n++;
					end else begin
						// lowered capacity still searches every held entry
						low = 0;
						for (int i = 1; i < held_n; i++)
							if ($signed(held_val[i]) < $signed(held_val[low]))
								low = i;
						if ($signed(v) > $signed(held_val[low]))
							open_slot(low, v, p);
					end
				end
			end
			tkv_pkg::CMD_CLEAR: held_n = 0;
			tkv_pkg::CMD_READ: begin
				if (held_n == 0) begin
					read_out[0] = '0;
					read_out[0].last = 1'b1;
					n = 1;
				end else begin
					for (int i = 0; i < held_n; i++) begin
						for (int k = 0; k < SLOT_POS; k++)
							shown[k] = (k < hit_count[i]) ? hit_pos[i][k] : 16'h0;
						read_out[i] = '0;
						read_out[i].valid = 1'b1;
						read_out[i].value = held_val[i];
						read_out[i].count = hit_count[i];
						read_out[i].pos_a = shown[0];
						read_out[i].pos_b = shown[1];
						read_out[i].pos_c = shown[2];
						read_out[i].pos_d = shown[3];
						read_out[i].ovf = hit_ovf[i];
						read_out[i].last = (i == held_n - 1);
					end
					n = held_n;
				end
			end
			default: ;
		endcase
		return n;
	endfunction

	function automatic entry_t lone_entry(logic valid, logic [31:0] v, logic [15:0] pa);
		entry_t e;
		e = '0;
		e.valid = valid;
		e.value = v;
		e.count = valid ? 3'd1 : 3'd0;
		e.pos_a = pa;
		e.last = 1'b1;
		return e;
	endfunction

	function automatic step_t plan_item(logic [1:0] cmd, logic [31:0] v, logic [15:0] p);
		step_t s;
		s.is_cfg = 1'b0;
		s.cmd = cmd;
		s.value = v;
		s.pos = p;
		s.cap = '0;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic step_t plan_cfg(logic [3:0] cap);
		step_t s;
		s = plan_item(tkv_pkg::CMD_OFFER, '0, '0);
		s.is_cfg = 1'b1;
		s.cap = cap;
		return s;
	endfunction

	function automatic step_t plan_check(entry_t want);
		step_t s;
		s = plan_item(tkv_pkg::CMD_READ, '0, '0);
		s.typed = 1'b1;
		s.want = want;
		return s;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic send_item(logic [1:0] cmd, logic [31:0] v, logic [15:0] p, bit drain_first);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap > 0 || (drain_first && expected_entries.size() != 0)) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain_first && expected_entries.size() != 0) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {p, v};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// capacity only changes with the block idle
	task automatic write_capacity(logic [3:0] cap);
		s_axis_tvalid <= 1'b0;
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tkv_pkg::ADDR_CAPACITY;
		pwdata <= {28'h0, cap};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		capacity = cap;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_item(logic [1:0] cmd, logic [31:0] v, logic [15:0] p, bit drain_first,
			bit typed, entry_t want);
		int n;
		send_item(cmd, v, p, drain_first);
		n = track_item(cmd, v, p);
		if (typed)
			expected_entries.push_back(want);
		else
			for (int i = 0; i < n; i++)
				expected_entries.push_back(read_out[i]);
	endtask

	initial begin : receiver
		int stall;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : beat_check
		entry_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_entries.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got value %h last %b",
					$time, m_axis_tdata[31:0], m_axis_tlast);
				errors++;
			end else begin
				want = expected_entries.pop_front();
				check_field("entry_valid", want.valid, m_axis_tuser);
				check_field("entry_value", want.value, m_axis_tdata[31:0]);
				check_field("position_count", want.count, m_axis_tdata[34:32]);
				check_field("position_a", want.pos_a, m_axis_tdata[50:35]);
				check_field("position_b", want.pos_b, m_axis_tdata[66:51]);
				check_field("position_c", want.pos_c, m_axis_tdata[82:67]);
				check_field("position_d", want.pos_d, m_axis_tdata[98:83]);
				check_field("positions_overflowed", want.ovf, m_axis_tdata[99]);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("top_k_values_with_positions_core verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		step_t plan [$];
		logic [3:0] phase_caps [6];
		logic [31:0] pool [12];
		logic [31:0] v;
		logic [1:0] cmd;
		int pick;

		// directed rows
		plan.push_back(plan_check(lone_entry(1'b0, '0, '0)));
		plan.push_back(plan_item(CMD_UNKNOWN, 32'hdeadbeef, 16'h8001));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h7fffffff, 16'hffff));
		plan.push_back(plan_check(lone_entry(1'b1, 32'h7fffffff, 16'hffff)));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h7fffffff, 16'h0001));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h7fffffff, 16'h0002));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h7fffffff, 16'h0003));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h7fffffff, 16'h0004)); // list full
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h80000000, 16'h0000));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h00000000, 16'h5555));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'hffffffff, 16'haaaa));
		plan.push_back(plan_item(tkv_pkg::CMD_READ, '0, '0));
		plan.push_back(plan_cfg(4'd2));                                // below entries in use
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h00000005, 16'h0010));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h80000001, 16'h0011)); // dropped
		plan.push_back(plan_item(tkv_pkg::CMD_READ, '0, '0));
		plan.push_back(plan_item(tkv_pkg::CMD_CLEAR, '0, '0));
		plan.push_back(plan_cfg(4'd0));                                // acts as one
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h00000003, 16'h1234));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h00000002, 16'h4321));
		plan.push_back(plan_item(tkv_pkg::CMD_OFFER, 32'h00000009, 16'h00ff));
		plan.push_back(plan_check(lone_entry(1'b1, 32'h00000009, 16'h00ff)));
		plan.push_back(plan_cfg(4'd15));                               // clamps to depth
		plan.push_back(plan_item(tkv_pkg::CMD_CLEAR, '0, '0));
		plan.push_back(plan_item(tkv_pkg::CMD_READ, '0, '0));

		phase_caps = '{4'd8, 4'd1, 4'd4, 4'd8, 4'd3, 4'd6};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_capacity(plan[i].cap);
			else
				run_item(plan[i].cmd, plan[i].value, plan[i].pos, 1'b0,
					plan[i].typed, plan[i].want);
		end

		foreach (phase_caps[ph]) begin
			write_capacity(phase_caps[ph]);
			calm = ($urandom_range(0, 3) == 0);
			// a small pool gives repeats, appends and list overflow
			pool[0] = 32'h80000000;
			pool[1] = 32'h7fffffff;
			pool[2] = 32'h00000000;
			pool[3] = 32'hffffffff;
			for (int i = 4; i < 12; i++)
				pool[i] = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 40) - 20;
			for (int k = 0; k < 20; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 76)
					cmd = tkv_pkg::CMD_OFFER;
				else if (pick < 90)
					cmd = tkv_pkg::CMD_READ;
				else if (pick < 96)
					cmd = tkv_pkg::CMD_CLEAR;
				else
					cmd = CMD_UNKNOWN;
				v = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 11)] : $urandom();
				run_item(cmd, v, 16'($urandom_range(0, 65535)),
					$urandom_range(0, 19) == 0, 1'b0, '0);
			end
			run_item(tkv_pkg::CMD_READ, '0, '0, 1'b0, 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("top_k_values_with_positions_core verification clean");
		else
			$display("top_k_values_with_positions_core verification failed");
		$finish;
	end

endmodule
